// ===== rtl/swq_pkg.sv =====
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and constants for the semaphore wait-queue table: field
// widths, result codes, command codes, sequencer states and scan status.
// ----------------------------------------------------------------------------
package swq_pkg;

  // fixed field widths
  localparam int KEY_W    = 28;
  localparam int PROC_W   = 5;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic CMD_BLOCK   = 1'b0;
  localparam logic CMD_UNBLOCK = 1'b1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BLK_RD,
    ST_BLK_WR,
    ST_UNB_RD,
    ST_UNB_EVAL,
    ST_UNB_NEXT,
    ST_RESULT
  } state_t;

  // flags reported by the slot scan unit
  typedef struct packed {
    logic done;
    logic found;
    logic free_found;
  } scan_status_t;

endpackage

// ===== rtl/swq_ram.sv =====
// ----------------------------------------------------------------------------
// swq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/swq_match.sv =====
// ----------------------------------------------------------------------------
// swq_match
// Slot scan unit: steps through the key store one slot per cycle, comparing
// each stored key with the request key through one shared comparator, and
// notes the matching slot and the lowest free slot.
// ----------------------------------------------------------------------------
module swq_match #(
  parameter int SEM_SLOTS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [swq_pkg::KEY_W-1:0]    key,
  input  logic [SEM_SLOTS-1:0]         slot_valid,
  output logic [$clog2(SEM_SLOTS)-1:0] rd_addr,
  input  logic [swq_pkg::KEY_W-1:0]    rd_data,
  output swq_pkg::scan_status_t        scan,
  output logic [$clog2(SEM_SLOTS)-1:0] hit_idx,
  output logic [$clog2(SEM_SLOTS)-1:0] free_idx
);

  localparam int SW = $clog2(SEM_SLOTS);

  logic [SW:0]   cnt;
  logic          running;
  logic          cmp_live;
  logic          cmp_last;
  logic [SW-1:0] cmp_idx;
  logic          last_slot;
  logic          cmp_valid;
  logic          key_eq;

  assign rd_addr   = cnt[SW-1:0];
  assign last_slot = (cnt == (SW+1)'(SEM_SLOTS - 1));
  assign cmp_valid = slot_valid[cmp_idx];
  assign key_eq    = (rd_data == key);

  // address counter, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      cmp_live <= 1'b0;
      cmp_last <= 1'b0;
    end else if (start) begin
      running  <= 1'b1;
      cmp_live <= 1'b0;
      cmp_last <= 1'b0;
    end else begin
      if (running && last_slot) begin
        running <= 1'b0;
      end
      cmp_live <= running;
      cmp_last <= running && last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
    end
    cmp_idx <= cnt[SW-1:0];
  end

  // shared key comparator and free slot tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (start) begin
      scan <= '0;
    end else begin
      scan.done <= cmp_live && cmp_last;
      if (cmp_live && cmp_valid && key_eq) begin
        scan.found <= 1'b1;
      end
      if (cmp_live && !cmp_valid && !scan.free_found) begin
        scan.free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_live && cmp_valid && key_eq) begin
      hit_idx <= cmp_idx;
    end
    if (cmp_live && !cmp_valid && !scan.free_found) begin
      free_idx <= cmp_idx;
    end
  end

endmodule

// ===== rtl/semaphore_wait_queue_table.sv =====
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table
// Table of semaphore slots, each keyed by a semaphore address and holding a
// FIFO of blocked process numbers linked through a per-process next store.
// ----------------------------------------------------------------------------
// One request at a time. A block or unblock that reaches the table scans every
// slot's key through one comparator, one slot per cycle. A missing key or a
// newly claimed slot is quickest to answer, an unblock that leaves waiters
// behind is slowest. A block of a process that is out of range or already
// blocked skips the scan and goes straight to the result. The scan is set by
// the single read port of the key store. After reset the block is ready at
// once: slot and blocked flags are cleared by reset. A new request is taken
// while the previous result still waits at the output.
module semaphore_wait_queue_table #(
  parameter int SEM_SLOTS = 32,
  parameter int MAX_PROCS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [swq_pkg::KEY_W-1:0]     sem_key,
  input  logic [swq_pkg::PROC_W-1:0]    proc_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swq_pkg::STATUS_W-1:0]  status,
  output logic [swq_pkg::PROC_W-1:0]    woken_proc,
  output logic                          slot_released
);

  localparam int SW = $clog2(SEM_SLOTS);
  localparam int PA = $clog2(MAX_PROCS);

  swq_pkg::state_t state, state_next;

  // request registers
  logic                        cmd_q;
  logic [swq_pkg::KEY_W-1:0]   key_q;
  logic [swq_pkg::PROC_W-1:0]  pid_q;

  // flag stores
  logic [SEM_SLOTS-1:0] slot_valid;
  logic [MAX_PROCS-1:0] blocked;

  // pending result
  swq_pkg::status_t            res_status;
  logic [swq_pkg::PROC_W-1:0]  res_woken;
  logic                        res_rel;

  // scan unit
  swq_pkg::scan_status_t       scan;
  logic [SW-1:0]               key_raddr;
  logic [swq_pkg::KEY_W-1:0]   key_rdata;
  logic [SW-1:0]               hit_idx;
  logic [SW-1:0]               free_idx;
  logic [SW-1:0]               sel_slot;

  // queue stores
  logic [swq_pkg::PROC_W-1:0]  head_rdata;
  logic [swq_pkg::PROC_W-1:0]  tail_rdata;
  logic [swq_pkg::PROC_W-1:0]  next_rdata;
  logic [swq_pkg::PROC_W-1:0]  head_wdata;

  // control
  logic          in_xfer;
  logic          in_range;
  logic [PA-1:0] in_pidx;
  logic [PA-1:0] pid_idx;
  logic [PA-1:0] head_pidx;
  logic [PA-1:0] tail_pidx;
  logic          out_free;
  logic          scan_start;
  logic          key_we;
  logic          head_we;
  logic          tail_we;
  logic          next_we;
  logic          valid_set;
  logic          valid_clr;
  logic          blk_set;
  logic          blk_clr;
  logic          head_is_tail;

  assign in_xfer      = in_valid && in_ready;
  assign in_range     = (32'(proc_id) < MAX_PROCS);
  assign in_pidx      = PA'(32'(proc_id));
  assign pid_idx      = PA'(32'(pid_q));
  assign head_pidx    = PA'(32'(head_rdata));
  assign tail_pidx    = PA'(32'(tail_rdata));
  assign out_free     = !out_valid || out_ready;
  assign sel_slot     = scan.found ? hit_idx : free_idx;
  assign head_is_tail = (head_rdata == tail_rdata);

  // slot scan unit
  swq_match #(
    .SEM_SLOTS(SEM_SLOTS)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .key       (key_q),
    .slot_valid(slot_valid),
    .rd_addr   (key_raddr),
    .rd_data   (key_rdata),
    .scan      (scan),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx)
  );

  // per-slot key, head and tail stores
  swq_ram #(
    .WIDTH(swq_pkg::KEY_W),
    .DEPTH(SEM_SLOTS)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(sel_slot),
    .wdata(key_q),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  swq_ram #(
    .WIDTH(swq_pkg::PROC_W),
    .DEPTH(SEM_SLOTS)
  ) u_head_ram (
    .clk  (clk),
    .we   (head_we),
    .waddr(sel_slot),
    .wdata(head_wdata),
    .raddr(sel_slot),
    .rdata(head_rdata)
  );

  swq_ram #(
    .WIDTH(swq_pkg::PROC_W),
    .DEPTH(SEM_SLOTS)
  ) u_tail_ram (
    .clk  (clk),
    .we   (tail_we),
    .waddr(sel_slot),
    .wdata(pid_q),
    .raddr(sel_slot),
    .rdata(tail_rdata)
  );

  // per-process link to the next waiter
  swq_ram #(
    .WIDTH(swq_pkg::PROC_W),
    .DEPTH(MAX_PROCS)
  ) u_next_ram (
    .clk  (clk),
    .we   (next_we),
    .waddr(tail_pidx),
    .wdata(pid_q),
    .raddr(head_pidx),
    .rdata(next_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      swq_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (cmd == swq_pkg::CMD_BLOCK && !in_range) begin
            state_next = swq_pkg::ST_RESULT;
          end else if (cmd == swq_pkg::CMD_BLOCK && blocked[in_pidx]) begin
            state_next = swq_pkg::ST_RESULT;
          end else begin
            state_next = swq_pkg::ST_SCAN;
          end
        end
      end
      swq_pkg::ST_SCAN: begin
        if (scan.done) begin
          priority if (scan.found && cmd_q == swq_pkg::CMD_UNBLOCK) begin
            state_next = swq_pkg::ST_UNB_RD;
          end else if (scan.found) begin
            state_next = swq_pkg::ST_BLK_RD;
          end else begin
            state_next = swq_pkg::ST_RESULT;
          end
        end
      end
      swq_pkg::ST_BLK_RD:   state_next = swq_pkg::ST_BLK_WR;
      swq_pkg::ST_BLK_WR:   state_next = swq_pkg::ST_RESULT;
      swq_pkg::ST_UNB_RD:   state_next = swq_pkg::ST_UNB_EVAL;
      swq_pkg::ST_UNB_EVAL: begin
        state_next = head_is_tail ? swq_pkg::ST_RESULT : swq_pkg::ST_UNB_NEXT;
      end
      swq_pkg::ST_UNB_NEXT: state_next = swq_pkg::ST_RESULT;
      swq_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = swq_pkg::ST_IDLE;
        end
      end
      default: state_next = swq_pkg::ST_IDLE;
    endcase
  end

  // store controls
  always_comb begin
    in_ready   = 1'b0;
    scan_start = 1'b0;
    key_we     = 1'b0;
    head_we    = 1'b0;
    head_wdata = pid_q;
    tail_we    = 1'b0;
    next_we    = 1'b0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    blk_set    = 1'b0;
    blk_clr    = 1'b0;
    unique case (state)
      swq_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        scan_start = in_valid;
      end
      swq_pkg::ST_SCAN: begin
        // claim a free slot for a new key
        if (scan.done && cmd_q == swq_pkg::CMD_BLOCK && !scan.found &&
            scan.free_found) begin
          key_we    = 1'b1;
          head_we   = 1'b1;
          tail_we   = 1'b1;
          valid_set = 1'b1;
          blk_set   = 1'b1;
        end
      end
      swq_pkg::ST_BLK_WR: begin
        // append behind the current tail
        next_we = 1'b1;
        tail_we = 1'b1;
        blk_set = 1'b1;
      end
      swq_pkg::ST_UNB_EVAL: begin
        blk_clr   = 1'b1;
        valid_clr = head_is_tail;
      end
      swq_pkg::ST_UNB_NEXT: begin
        head_we    = 1'b1;
        head_wdata = next_rdata;
      end
      swq_pkg::ST_BLK_RD,
      swq_pkg::ST_UNB_RD,
      swq_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // state and flag stores
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= swq_pkg::ST_IDLE;
      slot_valid <= '0;
      blocked    <= '0;
    end else begin
      state <= state_next;
      if (valid_set) begin
        slot_valid[sel_slot] <= 1'b1;
      end
      if (valid_clr) begin
        slot_valid[sel_slot] <= 1'b0;
      end
      if (blk_set) begin
        blocked[pid_idx] <= 1'b1;
      end
      if (blk_clr) begin
        blocked[head_pidx] <= 1'b0;
      end
    end
  end

  // request capture and pending result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q      <= cmd;
      key_q      <= sem_key;
      pid_q      <= proc_id;
      res_woken  <= '0;
      res_rel    <= 1'b0;
      res_status <= (cmd == swq_pkg::CMD_BLOCK && !in_range) ?
                    swq_pkg::STATUS_FULL : swq_pkg::STATUS_DONE;
    end
    if (state == swq_pkg::ST_SCAN && scan.done && !scan.found) begin
      if (cmd_q == swq_pkg::CMD_UNBLOCK) begin
        res_status <= swq_pkg::STATUS_NOT_FOUND;
      end else if (!scan.free_found) begin
        res_status <= swq_pkg::STATUS_FULL;
      end
    end
    if (state == swq_pkg::ST_UNB_EVAL) begin
      res_woken <= head_rdata;
      res_rel   <= head_is_tail;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == swq_pkg::ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == swq_pkg::ST_RESULT && out_free) begin
      status        <= res_status;
      woken_proc    <= res_woken;
      slot_released <= res_rel;
    end
  end

endmodule

// ===== verif/semaphore_wait_queue_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table_tb
// Self-checking bench for the semaphore wait-queue table. Requests are sent as
// valid/ready transfers. A behavioural copy of the table (slot keys, per-slot
// waiter FIFOs, per-process blocked flags) forms the expected result for each
// accepted request. A checker compares every result transfer with the oldest
// pending expectation. The run covers directed cases, random request mixes
// over a small key pool, a full table and a long result stall.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_table_tb;

  localparam int KEY_W        = swq_pkg::KEY_W;
  localparam int PROC_W       = swq_pkg::PROC_W;
  localparam int STATUS_W     = swq_pkg::STATUS_W;
  localparam int SLOTS        = 32;
  localparam int PROCS        = 32;
  localparam int KEY_POOL     = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [KEY_W-1:0] KEY_MAX = 28'hFFFFFFF;

  typedef struct packed {
    swq_pkg::status_t  status;
    logic [PROC_W-1:0] woken;
    logic              released;
  } wq_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = swq_pkg::CMD_BLOCK;
  logic [KEY_W-1:0]    sem_key = '0;
  logic [PROC_W-1:0]   proc_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PROC_W-1:0]   woken_proc;
  logic                slot_released;

  // shadow copy of the table
  bit                tbl_used     [SLOTS];
  logic [KEY_W-1:0]  tbl_key      [SLOTS];
  logic [PROC_W-1:0] fifo_head    [SLOTS];
  logic [PROC_W-1:0] fifo_tail    [SLOTS];
  logic [PROC_W-1:0] fifo_link    [PROCS];
  bit                proc_waiting [PROCS];

  wq_result_t       pending_outcomes [$];
  wq_result_t       want;
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               mismatch_count = 0;
  int               quiet_cycles   = 0;
  bit               bursty   = 1'b0;
  bit               calm     = 1'b0;
  bit               hold_req = 1'b0;

  semaphore_wait_queue_table #(
    .SEM_SLOTS (SLOTS),
    .MAX_PROCS (PROCS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .sem_key       (sem_key),
    .proc_id       (proc_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .woken_proc    (woken_proc),
    .slot_released (slot_released)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // expected outcome of one request, updating the shadow table
  function automatic wq_result_t predict_wait_queue(input logic c,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [PROC_W-1:0] p);
    wq_result_t r;
    int hit;
    int free;
    r.status   = swq_pkg::STATUS_DONE;
    r.woken    = '0;
    r.released = 1'b0;
    hit  = -1;
    free = -1;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (tbl_used[s] && tbl_key[s] == k) hit = s;
      if (!tbl_used[s]) free = s;
    end
    if (c == swq_pkg::CMD_BLOCK) begin
      if (int'(p) >= PROCS) begin
        r.status = swq_pkg::STATUS_FULL;
      end else if (!proc_waiting[p]) begin
        if (hit >= 0) begin
          fifo_link[fifo_tail[hit]] = p;
          fifo_tail[hit] = p;
          proc_waiting[p] = 1'b1;
        end else if (free >= 0) begin
          tbl_used[free]  = 1'b1;
          tbl_key[free]   = k;
          fifo_head[free] = p;
          fifo_tail[free] = p;
          proc_waiting[p] = 1'b1;
        end else begin
          r.status = swq_pkg::STATUS_FULL;
        end
      end
    end else if (hit < 0) begin
      r.status = swq_pkg::STATUS_NOT_FOUND;
    end else begin
      r.woken = fifo_head[hit];
      proc_waiting[r.woken] = 1'b0;
      if (r.woken == fifo_tail[hit]) begin
        tbl_used[hit] = 1'b0;
        r.released = 1'b1;
      end else begin
        fifo_head[hit] = fifo_link[r.woken];
      end
    end
    return r;
  endfunction

  // one request transfer; valid stays high for a back-to-back follower
  task automatic issue_request(input logic c, input logic [KEY_W-1:0] k,
                               input logic [PROC_W-1:0] p);
    int gap;
    if (bursty && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    sem_key  <= k;
    proc_id  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outcomes.push_back(predict_wait_queue(c, k, p));
  endtask

  // random request biased towards keys and processes that are in play
  task automatic random_item();
    int roll;
    int p;
    int start;
    logic [KEY_W-1:0] k;
    roll  = $urandom_range(0, 99);
    p     = $urandom_range(0, PROCS - 1);
    start = $urandom_range(0, SLOTS - 1);
    k     = key_pool[$urandom_range(0, KEY_POOL - 1)];
    if (roll < 52) begin
      if (roll < 8) k = KEY_W'($urandom_range(0, KEY_MAX));
      if (roll < 45) begin
        for (int i = 0; i < PROCS; i++) begin
          if (!proc_waiting[(p + i) % PROCS]) begin
            p = (p + i) % PROCS;
            break;
          end
        end
      end
      issue_request(swq_pkg::CMD_BLOCK, k, PROC_W'(p));
    end else begin
      if (roll < 92) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_used[(start + i) % SLOTS]) begin
            k = tbl_key[(start + i) % SLOTS];
            break;
          end
        end
      end else begin
        k = KEY_W'($urandom_range(0, KEY_MAX));
      end
      issue_request(swq_pkg::CMD_UNBLOCK, k, PROC_W'(p));
    end
  endtask

  // wake every waiter until no slot is in use
  task automatic drain_table();
    for (int s = 0; s < SLOTS; s++)
      while (tbl_used[s])
        issue_request(swq_pkg::CMD_UNBLOCK, tbl_key[s],
                      PROC_W'($urandom_range(0, PROCS - 1)));
  endtask

  // lookups on an empty table, extreme keys
  task automatic test_absent_key();
    issue_request(swq_pkg::CMD_UNBLOCK, '0, '0);
    issue_request(swq_pkg::CMD_UNBLOCK, KEY_MAX, 5'd31);
  endtask

  // waiters leave in arrival order, slot freed with the last one
  task automatic test_queue_order();
    issue_request(swq_pkg::CMD_BLOCK, '0, 5'd0);
    issue_request(swq_pkg::CMD_BLOCK, KEY_MAX, 5'd31);
    issue_request(swq_pkg::CMD_BLOCK, '0, 5'd5);
    issue_request(swq_pkg::CMD_BLOCK, '0, 5'd17);
    issue_request(swq_pkg::CMD_UNBLOCK, '0, 5'd31);
    issue_request(swq_pkg::CMD_UNBLOCK, '0, 5'd0);
    issue_request(swq_pkg::CMD_BLOCK, '0, 5'd0);
    issue_request(swq_pkg::CMD_UNBLOCK, '0, 5'd10);
    issue_request(swq_pkg::CMD_UNBLOCK, '0, 5'd21);
    issue_request(swq_pkg::CMD_UNBLOCK, '0, 5'd0);
    issue_request(swq_pkg::CMD_UNBLOCK, KEY_MAX, 5'd0);
  endtask

  // a process already waiting is not queued a second time
  task automatic test_repeat_block();
    issue_request(swq_pkg::CMD_BLOCK, 28'h5555555, 5'd10);
    issue_request(swq_pkg::CMD_BLOCK, 28'hAAAAAAA, 5'd10);
    issue_request(swq_pkg::CMD_BLOCK, 28'h5555555, 5'd10);
    issue_request(swq_pkg::CMD_UNBLOCK, 28'hAAAAAAA, 5'd21);
    issue_request(swq_pkg::CMD_UNBLOCK, 28'h5555555, 5'd10);
  endtask

  // random mix over a fresh key pool, idling switched per stretch
  task automatic test_random_mix(input int count);
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom_range(0, KEY_MAX));
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) bursty = !calm && ($urandom_range(0, 3) != 0);
      random_item();
    end
  endtask

  // every slot in use, one waiter each; with as many processes as slots the
  // extra block meets an already waiting process
  task automatic test_table_fill();
    int offset;
    offset = $urandom_range(0, PROCS - 1);
    drain_table();
    for (int i = 0; i < PROCS; i++)
      issue_request(swq_pkg::CMD_BLOCK,
                    (i == 0) ? '0 : (i == 1) ? KEY_MAX : KEY_W'($urandom_range(0, KEY_MAX)),
                    PROC_W'((offset + i) % PROCS));
    issue_request(swq_pkg::CMD_BLOCK, KEY_W'($urandom_range(0, KEY_MAX)),
                  PROC_W'($urandom_range(0, PROCS - 1)));
    issue_request(swq_pkg::CMD_UNBLOCK, KEY_W'($urandom_range(0, KEY_MAX)),
                  PROC_W'($urandom_range(0, PROCS - 1)));
    drain_table();
  endtask

  // results held back for a long stretch while requests keep coming
  task automatic test_backpressure();
    bursty   = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) random_item();
    in_valid <= 1'b0;
    while (hold_req) @(posedge clk);
  endtask

  initial begin : test_sequence
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_absent_key();
    test_queue_order();
    test_repeat_block();
    test_random_mix(500);
    test_table_fill();
    test_backpressure();
    test_random_mix(450);
    // last stretch without idling on either side
    calm   = 1'b1;
    bursty = 1'b0;
    test_random_mix(200);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: ready with random stalls and the long hold-off
  initial begin : result_sink
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (bursty && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d woken %0d released %0d",
                 $time, status, woken_proc, slot_released);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          mismatch_count++;
        end
        if (woken_proc !== want.woken) begin
          $display("%0t: woken_proc expected %0d actual %0d", $time, want.woken, woken_proc);
          mismatch_count++;
        end
        if (slot_released !== want.released) begin
          $display("%0t: slot_released expected %0d actual %0d",
                   $time, want.released, slot_released);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
